### sv/mbss_pkg.sv
`default_nettype none

package mbss_pkg;

  localparam int WIN_BYTES   = 16;
  localparam int CNT_BITS    = 33;
  localparam int DISP_BYTES  = 4;
  localparam int MAX_PATTERN = 16;
  // wide enough for any span and any window index
  localparam int SPAN_W      = $clog2(WIN_BYTES + MAX_PATTERN + DISP_BYTES);
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_BYTE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_DISP_OFFSET  = 3'd4,
    REG_RELATIVE     = 3'd5,
    REG_SECTION_ADDR = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] byte_mask;
    logic [4:0]  pattern_length;
    logic [3:0]  displacement_offset;
    logic        relative_mode;
    logic [63:0] section_address;
  } cfg_t;

endpackage

`default_nettype wire

### sv/mbss_in_if.sv
`default_nettype none

interface mbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### sv/mbss_out_if.sv
`default_nettype none

interface mbss_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

### sv/mbss_cfg.sv
`default_nettype none

module mbss_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mbss_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbss_pkg::DATA_W-1:0] pwdata,
  output logic      [mbss_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output mbss_pkg::cfg_t                  cfg
);
  import mbss_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PATTERN_LOW:  cfg_nxt.pattern_low         = pwdata;
        REG_PATTERN_HIGH: cfg_nxt.pattern_high        = pwdata;
        REG_BYTE_MASK:    cfg_nxt.byte_mask           = pwdata[15:0];
        REG_PATTERN_LEN:  cfg_nxt.pattern_length      = pwdata[4:0];
        REG_DISP_OFFSET:  cfg_nxt.displacement_offset = pwdata[3:0];
        REG_RELATIVE:     cfg_nxt.relative_mode       = pwdata[0];
        REG_SECTION_ADDR: cfg_nxt.section_address     = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PATTERN_LOW:  prdata = cfg_r.pattern_low;
      REG_PATTERN_HIGH: prdata = cfg_r.pattern_high;
      REG_BYTE_MASK:    prdata = {48'd0, cfg_r.byte_mask};
      REG_PATTERN_LEN:  prdata = {59'd0, cfg_r.pattern_length};
      REG_DISP_OFFSET:  prdata = {60'd0, cfg_r.displacement_offset};
      REG_RELATIVE:     prdata = {63'd0, cfg_r.relative_mode};
      REG_SECTION_ADDR: prdata = cfg_r.section_address;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pattern_low: 64'd0, pattern_high: 64'd0, byte_mask: 16'd0,
                 pattern_length: 5'd1, displacement_offset: 4'd0,
                 relative_mode: 1'b0, section_address: 64'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/masked_byte_signature_scanner.sv
`default_nettype none

// Masked byte signature scanner. Feed a section one byte per item, last_byte
// on its final byte. The block takes one byte every cycle unless the output
// stalls, and returns at most one result per section: found with the match
// (or, in relative mode, the resolved displacement target) on the first
// matching position, or a not-found item with address zero at the last byte.
// Data passes stage A, stage B and the output register; the rate of one
// byte per cycle is set by the combinational masked compare over the 16-byte
// shift window. Write the registers (8-byte stride, 64-bit data) only while
// no section is in flight. No clearing pass is needed after reset.
module masked_byte_signature_scanner (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mbss_in_if.sink                          in_if,
  mbss_out_if.source                       out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbss_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbss_pkg::DATA_W-1:0] pwdata,
  output logic      [mbss_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import mbss_pkg::*;

  localparam int POS_W = CNT_BITS + 1;

  cfg_t cfg;

  mbss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic [7:0] win_at(input logic [WIN_BYTES-1:0][7:0] w,
                                        input logic [SPAN_W-1:0] idx);
    logic [7:0] v;
    v = '0;
    for (int i = 0; i < WIN_BYTES; i++) begin
      if (idx == SPAN_W'(i)) v = w[i];
    end
    return v;
  endfunction

  // stage A: window after the shift, count before the increment
  logic                       a_v_r, a_v_nxt;
  logic [WIN_BYTES-1:0][7:0]  a_win_r, a_win_nxt, base_win;
  logic [CNT_BITS-1:0]        a_cb_r, a_cb_nxt, base_cb;
  logic                       a_last_r, a_last_nxt;
  // stage B: evaluated result
  logic                       b_v_r, b_v_nxt;
  logic                       b_found_r, b_found_nxt;
  logic [POS_W-1:0]           b_pos_r, b_pos_nxt;
  logic [31:0]                b_disp_r, b_disp_nxt;
  // output register
  logic                       out_v_r, out_v_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [63:0]                out_addr_r, out_addr_nxt;
  logic                       match_done_r, match_done_nxt;

  logic out_adv, b_go, b_free, a_go, a_free, in_go;
  logic hit, emit, reach, cmp_ok;
  logic [SPAN_W-1:0] len, span, off_ext;
  logic [POS_W-1:0]  cbp1, span_ext;
  logic [31:0]       disp;

  assign out_adv = !out_v_r || out_if.ready;
  assign b_go    = b_v_r && out_adv;
  assign b_free  = !b_v_r || out_adv;
  assign a_go    = a_v_r && b_free;
  assign a_free  = !a_v_r || b_free;
  assign in_go   = in_if.valid && a_free;

  assign in_if.ready          = a_free;
  assign out_if.valid         = out_v_r;
  assign out_if.found         = out_found_r;
  assign out_if.match_address = out_addr_r;

  // window and count start over after a last byte
  always_comb begin
    base_win = a_last_r ? '0 : a_win_r;
    if (a_last_r) begin
      base_cb = '0;
    end else if (a_cb_r == '1) begin
      base_cb = a_cb_r;
    end else begin
      base_cb = a_cb_r + 1'b1;
    end
    a_win_nxt    = a_win_r;
    a_cb_nxt     = a_cb_r;
    a_last_nxt   = a_last_r;
    if (in_go) begin
      for (int i = WIN_BYTES - 1; i > 0; i--) a_win_nxt[i] = base_win[i-1];
      a_win_nxt[0] = in_if.data_byte;
      a_cb_nxt     = base_cb;
      a_last_nxt   = in_if.last_byte;
    end
    a_v_nxt = in_go || (a_v_r && !a_go);
  end

  // span, masked compare and displacement pick
  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      len = SPAN_W'(1);
    end else if (cfg.pattern_length > 5'(MAX_PATTERN)) begin
      len = SPAN_W'(MAX_PATTERN);
    end else begin
      len = SPAN_W'(cfg.pattern_length);
    end
    off_ext = SPAN_W'(cfg.displacement_offset);
    span    = len;
    if (cfg.relative_mode && (off_ext + SPAN_W'(DISP_BYTES) > len))
      span = off_ext + SPAN_W'(DISP_BYTES);
    cbp1     = {1'b0, a_cb_r} + 1'b1;
    span_ext = POS_W'(span);
    reach    = (span <= SPAN_W'(WIN_BYTES)) && (cbp1 >= span_ext);
    cmp_ok   = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((SPAN_W'(k) < len) && cfg.byte_mask[k] &&
          (win_at(a_win_r, span - 1'b1 - SPAN_W'(k)) !=
           (k < 8 ? cfg.pattern_low[8*(k%8) +: 8] : cfg.pattern_high[8*(k%8) +: 8])))
        cmp_ok = 1'b0;
    end
    for (int j = 0; j < DISP_BYTES; j++) begin
      disp[8*j +: 8] = win_at(a_win_r, span - 1'b1 - off_ext - SPAN_W'(j));
    end
    hit  = !match_done_r && reach && cmp_ok;
    emit = !match_done_r && (hit || a_last_r);
  end

  always_comb begin
    match_done_nxt = match_done_r;
    b_found_nxt    = b_found_r;
    b_pos_nxt      = b_pos_r;
    b_disp_nxt     = b_disp_r;
    b_v_nxt        = b_v_r && !b_go;
    if (a_go) begin
      match_done_nxt = a_last_r ? 1'b0 : (match_done_r || hit);
      if (emit) begin
        b_v_nxt     = 1'b1;
        b_found_nxt = hit;
        b_pos_nxt   = cbp1 - span_ext;
        b_disp_nxt  = disp;
      end
    end
  end

  // resolve the address on the way to the output register
  always_comb begin
    out_v_nxt     = out_v_r && !out_if.ready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (b_go) begin
      out_v_nxt     = 1'b1;
      out_found_nxt = b_found_r;
      if (!b_found_r) begin
        out_addr_nxt = '0;
      end else if (cfg.relative_mode) begin
        out_addr_nxt = cfg.section_address + 64'(b_pos_r)
                     + 64'(cfg.displacement_offset) + 64'(DISP_BYTES)
                     + {{32{b_disp_r[31]}}, b_disp_r};
      end else begin
        out_addr_nxt = cfg.section_address + 64'(b_pos_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r        <= 1'b0;
      a_last_r     <= 1'b1;
      a_cb_r       <= '0;
      a_win_r      <= '0;
      b_v_r        <= 1'b0;
      out_v_r      <= 1'b0;
      match_done_r <= 1'b0;
    end else begin
      a_v_r        <= a_v_nxt;
      a_last_r     <= a_last_nxt;
      a_cb_r       <= a_cb_nxt;
      a_win_r      <= a_win_nxt;
      b_v_r        <= b_v_nxt;
      out_v_r      <= out_v_nxt;
      match_done_r <= match_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_found_r   <= b_found_nxt;
    b_pos_r     <= b_pos_nxt;
    b_disp_r    <= b_disp_nxt;
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

`ifndef NO_ASSERTIONS
  a_last_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_last_r) |=> !match_done_r)
    else $error("match flag survived the end of a section");

  a_done_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && match_done_r && b_free) |=> !b_v_r)
    else $error("second result produced for one section");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_found_r) |-> (out_addr_r == '0))
    else $error("not-found item carries a nonzero address");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !a_v_r |-> in_if.ready)
    else $error("input stalled with an empty input stage");
`endif

endmodule

`default_nettype wire

### tb/scan_checker.sv
module scan_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  mbss_in_if                          in_mon,
  mbss_out_if                         out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [mbss_pkg::ADDR_W-1:0] paddr,
  input  logic [mbss_pkg::DATA_W-1:0] pwdata,
  output int                          errors,
  output int                          pending
);
  import mbss_pkg::*;

  typedef struct packed {
    logic        found;
    logic [63:0] addr;
  } scan_result_t;

  cfg_t                shadow;
  logic [7:0]          window [WIN_BYTES];
  logic [CNT_BITS-1:0] seen_bytes;
  logic                matched;
  scan_result_t        hits_due[$];
  int                  fail_count;

  // byte k of a candidate whose span ends at the newest byte
  function automatic logic [7:0] span_byte(input int span, input int k);
    int idx;
    idx = span - 1 - k;
    if (idx < 0 || idx >= WIN_BYTES) return 8'h00;
    return window[idx];
  endfunction

  task automatic clear_section();
    for (int k = 0; k < WIN_BYTES; k++) window[k] = 8'h00;
    seen_bytes = '0;
    matched = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic is_last);
    logic [127:0] pat;
    logic [31:0]  disp32;
    logic [63:0]  addr;
    int           len, off, span;
    logic         ok;
    scan_result_t res;
    for (int k = WIN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (!matched) begin
      pat = {shadow.pattern_high, shadow.pattern_low};
      len = int'(shadow.pattern_length);
      if (len == 0) len = 1;
      if (len > MAX_PATTERN) len = MAX_PATTERN;
      off = int'(shadow.displacement_offset);
      span = len;
      if (shadow.relative_mode && off + DISP_BYTES > span) span = off + DISP_BYTES;
      if (span <= WIN_BYTES && 64'(seen_bytes) + 64'd1 >= 64'(span)) begin
        ok = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (shadow.byte_mask[k] && span_byte(span, k) != pat[8*k +: 8]) ok = 1'b0;
        end
        if (ok) begin
          addr = shadow.section_address + 64'(seen_bytes) + 64'd1 - 64'(span);
          if (shadow.relative_mode) begin
            disp32 = {span_byte(span, off + 3), span_byte(span, off + 2),
                      span_byte(span, off + 1), span_byte(span, off)};
            addr = addr + 64'(off + DISP_BYTES) + {{32{disp32[31]}}, disp32};
          end
          res.found = 1'b1;
          res.addr = addr;
          hits_due.insert(hits_due.size(), res);
          matched = 1'b1;
        end
      end
    end
    if (seen_bytes != '1) seen_bytes = seen_bytes + 1'b1;
    if (is_last) begin
      if (!matched) begin
        res.found = 1'b0;
        res.addr = 64'd0;
        hits_due.insert(hits_due.size(), res);
      end
      clear_section();
    end
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    logic         bad;
    if (!rst_n) begin
      shadow = '0;
      shadow.pattern_length = 5'd1;
      clear_section();
      hits_due.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
          REG_PATTERN_LOW:  shadow.pattern_low = pwdata;
          REG_PATTERN_HIGH: shadow.pattern_high = pwdata;
          REG_BYTE_MASK:    shadow.byte_mask = pwdata[15:0];
          REG_PATTERN_LEN:  shadow.pattern_length = pwdata[4:0];
          REG_DISP_OFFSET:  shadow.displacement_offset = pwdata[3:0];
          REG_RELATIVE:     shadow.relative_mode = pwdata[0];
          REG_SECTION_ADDR: shadow.section_address = pwdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (hits_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual found=%0b address=%h",
                   $time, out_mon.found, out_mon.match_address);
          fail_count++;
        end else begin
          want = hits_due.pop_front();
          bad = 1'b0;
          if (out_mon.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, out_mon.found);
            bad = 1'b1;
          end
          if (out_mon.match_address !== want.addr) begin
            $display("%0t: match_address mismatch, expected %h, actual %h",
                     $time, want.addr, out_mon.match_address);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
    errors <= fail_count;
    pending <= hits_due.size();
  end

endmodule

### tb/testbench.sv
module testbench;
  import mbss_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;

  mbss_in_if  scan_in ();
  mbss_out_if scan_out ();

  int   errors, pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_ack = 1'b0;
  cfg_t cur_cfg;

  masked_byte_signature_scanner i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (scan_in),
    .out_if  (scan_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scan_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (scan_in),
    .out_mon (scan_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin : result_sink
    int gap;
    scan_out.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_ack) begin
        scan_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ack <= 1'b1;
      end else begin
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
          scan_out.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      scan_out.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // keep valid high across back-to-back items; drop it only for a gap
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      scan_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_in.valid <= 1'b1;
    scan_in.data_byte <= b;
    scan_in.last_byte <= is_last;
    do @(posedge clk); while (!scan_in.ready);
    items_sent++;
  endtask

  task automatic drain();
    scan_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_config();
    apb_write(REG_PATTERN_LOW, cur_cfg.pattern_low);
    apb_write(REG_PATTERN_HIGH, cur_cfg.pattern_high);
    apb_write(REG_BYTE_MASK, 64'(cur_cfg.byte_mask));
    apb_write(REG_PATTERN_LEN, 64'(cur_cfg.pattern_length));
    apb_write(REG_DISP_OFFSET, 64'(cur_cfg.displacement_offset));
    apb_write(REG_RELATIVE, 64'(cur_cfg.relative_mode));
    apb_write(REG_SECTION_ADDR, cur_cfg.section_address);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   r;
    c.pattern_low = {$urandom, $urandom};
    c.pattern_high = {$urandom, $urandom};
    r = $urandom_range(19, 0);
    if (r == 0) c.pattern_length = 5'd0;
    else if (r == 1) c.pattern_length = 5'($urandom_range(31, 17));
    else if (r < 5) c.pattern_length = 5'd16;
    else if (r < 8) c.pattern_length = 5'($urandom_range(15, 7));
    else c.pattern_length = 5'($urandom_range(6, 1));
    r = $urandom_range(9, 0);
    if (r < 4) c.byte_mask = 16'hFFFF;
    else if (r == 4) c.byte_mask = 16'h0000;
    else c.byte_mask = 16'($urandom);
    c.relative_mode = 1'($urandom_range(1, 0));
    r = $urandom_range(19, 0);
    if (r == 0) c.displacement_offset = 4'($urandom_range(15, 13));
    else if (r < 3) c.displacement_offset = 4'd12;
    else c.displacement_offset = 4'($urandom_range(8, 0));
    r = $urandom_range(4, 0);
    case (r)
      0: c.section_address = 64'd0;
      1: c.section_address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40, 0));
      2: c.section_address = {$urandom, $urandom};
      default: c.section_address = 64'($urandom_range(65535, 0));
    endcase
    return c;
  endfunction

  // one section of n bytes; plant the pattern at plant_at unless it is negative
  task automatic scan_section(input int n, input int plant_at);
    logic [127:0] pat;
    logic [7:0]   bytes_q[$];
    int           len, idx;
    pat = {cur_cfg.pattern_high, cur_cfg.pattern_low};
    len = int'(cur_cfg.pattern_length);
    if (len == 0) len = 1;
    if (len > MAX_PATTERN) len = MAX_PATTERN;
    for (int k = 0; k < n; k++) begin
      idx = $urandom_range(15, 0);
      if ($urandom_range(9, 0) < 4) bytes_q.insert(bytes_q.size(), pat[8*idx +: 8]);
      else bytes_q.insert(bytes_q.size(), 8'($urandom));
    end
    if (plant_at >= 0) begin
      for (int k = 0; k < len && plant_at + k < n; k++) begin
        if (cur_cfg.byte_mask[k]) bytes_q[plant_at + k] = pat[8*k +: 8];
      end
    end
    for (int k = 0; k < n; k++) send_byte(bytes_q[k], k == n - 1);
  endtask

  initial begin : stimulus
    int n, sections;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    scan_in.valid = 1'b0;
    scan_in.data_byte = 8'h00;
    scan_in.last_byte = 1'b0;
    cur_cfg = '0;
    cur_cfg.pattern_length = 5'd1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one wildcard byte, so the first byte matches
    scan_section(2, -1);
    drain();

    // full 16-byte pattern ending on the last byte, at the top address
    cur_cfg.pattern_low = {$urandom, $urandom};
    cur_cfg.pattern_high = {$urandom, $urandom};
    cur_cfg.byte_mask = 16'hFFFF;
    cur_cfg.pattern_length = 5'd16;
    cur_cfg.section_address = 64'hFFFF_FFFF_FFFF_FFFF;
    set_config();
    scan_section(16, 0);
    drain();

    // length above range clamps to 16: a short section cannot match
    cur_cfg.pattern_length = 5'd31;
    cur_cfg.byte_mask = 16'h0000;
    set_config();
    scan_section(3, 0);
    drain();

    // displacement reaching past the window never matches
    cur_cfg.relative_mode = 1'b1;
    cur_cfg.displacement_offset = 4'd15;
    cur_cfg.pattern_length = 5'd0;
    set_config();
    scan_section(3, 0);
    drain();

    // relative target, displacement at offset 2, overlapping a 4-byte pattern
    cur_cfg.pattern_length = 5'd4;
    cur_cfg.byte_mask = 16'h000F;
    cur_cfg.displacement_offset = 4'd2;
    cur_cfg.section_address = 64'd0;
    set_config();
    scan_section(6, 0);
    drain();

    // length zero acts as one
    cur_cfg.relative_mode = 1'b0;
    cur_cfg.pattern_length = 5'd0;
    cur_cfg.byte_mask = 16'hFFFF;
    set_config();
    scan_section(1, 0);
    drain();

    // every section of one or two bytes matches; hold the result side so that the input stalls
    cur_cfg.pattern_length = 5'd1;
    cur_cfg.byte_mask = 16'h0000;
    cur_cfg.section_address = {$urandom, $urandom};
    set_config();
    no_idle <= 1'b1;
    hold_req <= 1'b1;
    for (int s = 0; s < 40; s++) scan_section($urandom_range(2, 1), 0);
    drain();

    while (items_sent < ITEM_TARGET) begin
      cur_cfg = random_cfg();
      set_config();
      no_idle <= ($urandom_range(3, 0) == 0);
      sections = $urandom_range(10, 4);
      for (int s = 0; s < sections; s++) begin
        if ($urandom_range(9, 0) == 0) n = $urandom_range(64, 17);
        else n = $urandom_range(24, 1);
        if ($urandom_range(3, 0) != 0) scan_section(n, $urandom_range(n - 1, 0));
        else scan_section(n, -1);
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### masked_byte_signature_scanner.f
sv/mbss_pkg.sv
sv/mbss_in_if.sv
sv/mbss_out_if.sv
sv/mbss_cfg.sv
sv/masked_byte_signature_scanner.sv
tb/scan_checker.sv
tb/testbench.sv
